// File: rtl/core/ams_pkg.sv
// ----------------------------------------------------------------------------
// ams_pkg
// Shared types and constants of the annotation metadata stream parser.
// ----------------------------------------------------------------------------
package ams_pkg;

	localparam int unsigned MARK_LEN = 25;

	localparam logic [7:0] MARKER [MARK_LEN] = '{
		8'h7B, 8'h5C, 8'h2A, 8'h5C, 8'h77, 8'h6F, 8'h72, 8'h64, 8'h63, 8'h72,
		8'h61, 8'h66, 8'h74, 8'h63, 8'h6F, 8'h6D, 8'h6D, 8'h65, 8'h6E, 8'h74,
		8'h73, 8'h20, 8'h76, 8'h31, 8'h3B
	};

	localparam logic [1:0] KIND_HEADER = 2'd0;
	localparam logic [1:0] KIND_UNIT   = 2'd1;
	localparam logic [1:0] KIND_STATUS = 2'd2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_MALFORMED = 2'd2;

	localparam logic [1:0] REG_COUNT_LIMIT    = 2'd0;
	localparam logic [1:0] REG_TEXT_LIMIT     = 2'd1;
	localparam logic [1:0] REG_POSITION_LIMIT = 2'd2;
	localparam logic [1:0] REG_GROUP_LIMIT    = 2'd3;

	localparam logic [11:0] COUNT_LIMIT_RST    = 12'd1024;
	localparam logic [15:0] TEXT_LIMIT_RST     = 16'd1024;
	localparam logic [30:0] POSITION_LIMIT_RST = 31'h7FFF_FFFF;
	localparam logic [25:0] GROUP_LIMIT_RST    = 26'd16777216;

	typedef struct packed {
		logic [11:0] count_limit;
		logic [15:0] text_limit;
		logic [30:0] position_limit;
		logic [25:0] group_limit;
	} ams_limits_t;

	typedef struct packed {
		logic [1:0]  item_kind;
		logic [11:0] entry_index;
		logic [30:0] start_pos;
		logic [30:0] end_pos;
		logic [15:0] text_len;
		logic [15:0] code_unit;
		logic [1:0]  parse_status;
		logic [11:0] entry_count;
	} ams_result_t;

endpackage

// File: rtl/core/ams_parser.sv
// ----------------------------------------------------------------------------
// ams_parser
// Per-byte parse state and the result the current byte produces.
// ----------------------------------------------------------------------------
module ams_parser (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  logic [7:0]           data_byte,
	input  logic                 last_byte,
	input  ams_pkg::ams_limits_t limits,
	output logic                 res_valid,
	output ams_pkg::ams_result_t result
);

	localparam logic [3:0] PH_SEARCH = 4'd0;
	localparam logic [3:0] PH_COUNT  = 4'd1;
	localparam logic [3:0] PH_START  = 4'd2;
	localparam logic [3:0] PH_END    = 4'd3;
	localparam logic [3:0] PH_LEN    = 4'd4;
	localparam logic [3:0] PH_HEX    = 4'd5;
	localparam logic [3:0] PH_SEMI   = 4'd6;
	localparam logic [3:0] PH_CLOSE  = 4'd7;
	localparam logic [3:0] PH_AFTER  = 4'd8;

	localparam logic [4:0] MARK_LAST = 5'(ams_pkg::MARK_LEN - 1);
	localparam logic [25:0] MARK_BYTES = 26'(ams_pkg::MARK_LEN);

	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_CLOSE = 8'h7D;

	logic [4:0]  match_q, n_match;
	logic [3:0]  phase_q, n_phase;
	logic [30:0] acc_q, n_acc;
	logic        seen_q, n_seen;
	logic [11:0] decl_q, n_decl;
	logic [11:0] done_q, n_done;
	logic [30:0] start_q, n_start;
	logic [30:0] end_q, n_end;
	logic [15:0] units_q, n_units;
	logic [1:0]  hpos_q, n_hpos;
	logic [15:0] hacc_q, n_hacc;
	logic [25:0] group_q, n_group;
	logic        err_q, err;

	logic        emit_hdr, emit_unit;
	logic [15:0] unit_val;
	logic [26:0] grp_inc;
	logic [4:0]  mpos;
	logic        mk_hit, mk_done;
	logic [4:0]  mk_next;
	logic        is_digit;
	logic [34:0] num_next;
	logic [30:0] num_lim;
	logic        num_over;
	logic [7:0]  delim;
	logic        hex_ok;
	logic [3:0]  hex_val;
	logic [15:0] hacc_new;
	logic [15:0] units_dec;
	logic [11:0] done_inc;
	logic [1:0]  status;

	always_comb begin
		mpos    = (match_q > MARK_LAST) ? 5'd0 : match_q;
		mk_hit  = data_byte == ams_pkg::MARKER[mpos];
		mk_done = mk_hit && (mpos == MARK_LAST);
		if (mk_hit) begin
			mk_next = mk_done ? 5'd0 : mpos + 5'd1;
		end else begin
			mk_next = (data_byte == ams_pkg::MARKER[0]) ? 5'd1 : 5'd0;
		end
	end

	always_comb begin
		is_digit = (data_byte >= 8'h30) && (data_byte <= 8'h39);
		num_next = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1)
			+ {31'b0, data_byte[3:0]};
		if (phase_q == PH_COUNT) begin
			num_lim = {19'b0, limits.count_limit};
			delim   = CH_SEMI;
		end else if (phase_q == PH_LEN) begin
			num_lim = {15'b0, limits.text_limit};
			delim   = CH_COMMA;
		end else begin
			num_lim = limits.position_limit;
			delim   = CH_COMMA;
		end
		num_over = num_next > {4'b0, num_lim};
	end

	always_comb begin
		hex_ok  = 1'b1;
		hex_val = data_byte[3:0];
		if (data_byte >= 8'h30 && data_byte <= 8'h39) begin
			hex_val = data_byte[3:0];
		end else if ((data_byte >= 8'h41 && data_byte <= 8'h46)
			|| (data_byte >= 8'h61 && data_byte <= 8'h66)) begin
			hex_val = data_byte[3:0] + 4'd9;
		end else begin
			hex_ok = 1'b0;
		end
		hacc_new  = {hacc_q[11:0], hex_val};
		units_dec = (units_q != 16'd0) ? units_q - 16'd1 : units_q;
		done_inc  = done_q + 12'd1;
	end

	always_comb begin
		n_match   = match_q;
		n_phase   = phase_q;
		n_acc     = acc_q;
		n_seen    = seen_q;
		n_decl    = decl_q;
		n_done    = done_q;
		n_start   = start_q;
		n_end     = end_q;
		n_units   = units_q;
		n_hpos    = hpos_q;
		n_hacc    = hacc_q;
		n_group   = group_q;
		err       = err_q;
		emit_hdr  = 1'b0;
		emit_unit = 1'b0;
		unit_val  = '0;
		grp_inc   = {1'b0, group_q} + 27'd1;

		if (!err && phase_q != PH_SEARCH && phase_q != PH_AFTER) begin
			if (grp_inc > {1'b0, limits.group_limit}) begin
				err = 1'b1;
			end else begin
				n_group = grp_inc[25:0];
			end
		end

		if (!err) begin
			unique case (phase_q) inside
				PH_SEARCH: begin
					n_match = mk_next;
					if (mk_done) begin
						n_phase = PH_COUNT;
						n_acc   = '0;
						n_seen  = 1'b0;
						n_group = MARK_BYTES;
						if (MARK_BYTES > limits.group_limit) err = 1'b1;
					end
				end
				PH_COUNT, PH_START, PH_END, PH_LEN: begin
					if (is_digit) begin
						if (num_over) begin
							err = 1'b1;
						end else begin
							n_acc  = num_next[30:0];
							n_seen = 1'b1;
						end
					end else if (data_byte == delim && seen_q) begin
						n_acc  = '0;
						n_seen = 1'b0;
						if (phase_q == PH_COUNT) begin
							n_decl  = acc_q[11:0];
							n_done  = '0;
							n_phase = (acc_q[11:0] == 12'd0) ? PH_CLOSE : PH_START;
						end else if (phase_q == PH_START) begin
							n_start = acc_q;
							n_phase = PH_END;
						end else if (phase_q == PH_END) begin
							n_end = acc_q;
							if (acc_q < start_q) err = 1'b1;
							else n_phase = PH_LEN;
						end else begin
							if (acc_q == 31'd0) begin
								err = 1'b1;
							end else begin
								n_units  = acc_q[15:0];
								n_hpos   = '0;
								n_hacc   = '0;
								n_phase  = PH_HEX;
								emit_hdr = 1'b1;
							end
						end
					end else begin
						err = 1'b1;
					end
				end
				PH_HEX: begin
					if (!hex_ok) begin
						err = 1'b1;
					end else if (hpos_q == 2'd3) begin
						n_hpos = '0;
						if (hacc_new == 16'd0) begin
							err = 1'b1;
						end else begin
							unit_val  = hacc_new;
							n_hacc    = '0;
							emit_unit = 1'b1;
							n_units   = units_dec;
							if (units_dec == 16'd0) n_phase = PH_SEMI;
						end
					end else begin
						n_hacc = hacc_new;
						n_hpos = hpos_q + 2'd1;
					end
				end
				PH_SEMI: begin
					if (data_byte != CH_SEMI) begin
						err = 1'b1;
					end else begin
						n_done  = done_inc;
						n_phase = (done_inc >= decl_q) ? PH_CLOSE : PH_START;
					end
				end
				PH_CLOSE: begin
					if (data_byte != CH_CLOSE) begin
						err = 1'b1;
					end else begin
						n_phase = PH_AFTER;
						n_match = '0;
					end
				end
				PH_AFTER: begin
					n_match = mk_next;
					if (mk_done) err = 1'b1;
				end
				default: err = 1'b1;
			endcase
		end
	end

	always_comb begin
		if (err) status = ams_pkg::ST_MALFORMED;
		else if (n_phase == PH_SEARCH) status = ams_pkg::ST_NOT_FOUND;
		else if (n_phase == PH_AFTER) status = ams_pkg::ST_OK;
		else status = ams_pkg::ST_MALFORMED;

		result = '0;
		if (last_byte) begin
			result.item_kind    = ams_pkg::KIND_STATUS;
			result.parse_status = status;
			result.entry_count  = (status == ams_pkg::ST_OK) ? n_decl : 12'd0;
		end else if (emit_hdr) begin
			result.item_kind   = ams_pkg::KIND_HEADER;
			result.entry_index = n_done;
			result.start_pos   = n_start;
			result.end_pos     = n_end;
			result.text_len    = n_units;
		end else begin
			result.item_kind   = ams_pkg::KIND_UNIT;
			result.entry_index = n_done;
			result.code_unit   = unit_val;
		end
		res_valid = last_byte || (!err && (emit_hdr || emit_unit));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= '0;
			phase_q <= PH_SEARCH;
			acc_q   <= '0;
			seen_q  <= 1'b0;
			decl_q  <= '0;
			done_q  <= '0;
			start_q <= '0;
			end_q   <= '0;
			units_q <= '0;
			hpos_q  <= '0;
			hacc_q  <= '0;
			group_q <= '0;
			err_q   <= 1'b0;
		end else if (accept) begin
			if (last_byte) begin
				match_q <= '0;
				phase_q <= PH_SEARCH;
				acc_q   <= '0;
				seen_q  <= 1'b0;
				decl_q  <= '0;
				done_q  <= '0;
				start_q <= '0;
				end_q   <= '0;
				units_q <= '0;
				hpos_q  <= '0;
				hacc_q  <= '0;
				group_q <= '0;
				err_q   <= 1'b0;
			end else begin
				match_q <= n_match;
				phase_q <= n_phase;
				acc_q   <= n_acc;
				seen_q  <= n_seen;
				decl_q  <= n_decl;
				done_q  <= n_done;
				start_q <= n_start;
				end_q   <= n_end;
				units_q <= n_units;
				hpos_q  <= n_hpos;
				hacc_q  <= n_hacc;
				group_q <= n_group;
				err_q   <= err;
			end
		end
	end

endmodule

// File: rtl/core/ams_out_buf.sv
// ----------------------------------------------------------------------------
// ams_out_buf
// Output register with one skid entry between parser and result channel.
// ----------------------------------------------------------------------------
module ams_out_buf (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  ams_pkg::ams_result_t push_data,
	input  logic                 out_stall,
	output logic                 out_valid,
	output ams_pkg::ams_result_t out_data,
	output logic                 full
);

	logic                 out_valid_q;
	logic                 skid_valid_q;
	ams_pkg::ams_result_t out_data_q;
	ams_pkg::ams_result_t skid_data_q;
	logic                 take;

	assign take      = out_valid_q && !out_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign full      = skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (take) skid_valid_q <= 1'b0;
		end else if (push) begin
			if (!out_valid_q || take) out_valid_q <= 1'b1;
			else skid_valid_q <= 1'b1;
		end else if (take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take) out_data_q <= skid_data_q;
		end else if (push) begin
			if (!out_valid_q || take) out_data_q <= push_data;
			else skid_data_q <= push_data;
		end
	end

endmodule

// File: rtl/core/annotation_metadata_stream_parser.sv
// ----------------------------------------------------------------------------
// annotation_metadata_stream_parser
// A result enters the output buffer with the byte transfer that causes it.
// Throughput: one byte per cycle while the output buffer is not full; each
// byte updates the parse state as it is taken, and a two-entry output buffer
// keeps input open while a result waits. Reset clears parse state, output
// buffer and sets the limits to their defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module annotation_metadata_stream_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  item_kind,
	output logic [11:0] entry_index,
	output logic [30:0] start_pos,
	output logic [30:0] end_pos,
	output logic [15:0] text_len,
	output logic [15:0] code_unit,
	output logic [1:0]  parse_status,
	output logic [11:0] entry_count,
	input  logic        cfg_write,
	input  logic [1:0]  cfg_index,
	input  logic [30:0] cfg_data
);

	ams_pkg::ams_limits_t limits_q;
	ams_pkg::ams_result_t res;
	ams_pkg::ams_result_t out_data;
	logic                 res_valid;
	logic                 accept;
	logic                 buf_full;

	assign in_stall = buf_full;
	assign accept   = in_valid && !buf_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limits_q.count_limit    <= ams_pkg::COUNT_LIMIT_RST;
			limits_q.text_limit     <= ams_pkg::TEXT_LIMIT_RST;
			limits_q.position_limit <= ams_pkg::POSITION_LIMIT_RST;
			limits_q.group_limit    <= ams_pkg::GROUP_LIMIT_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				ams_pkg::REG_COUNT_LIMIT:    limits_q.count_limit <= cfg_data[11:0];
				ams_pkg::REG_TEXT_LIMIT:     limits_q.text_limit <= cfg_data[15:0];
				ams_pkg::REG_POSITION_LIMIT: limits_q.position_limit <= cfg_data;
				ams_pkg::REG_GROUP_LIMIT:    limits_q.group_limit <= cfg_data[25:0];
				default:                     limits_q <= limits_q;
			endcase
		end
	end

	ams_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.limits    (limits_q),
		.res_valid (res_valid),
		.result    (res)
	);

	ams_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept && res_valid),
		.push_data (res),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_data  (out_data),
		.full      (buf_full)
	);

	assign item_kind    = out_data.item_kind;
	assign entry_index  = out_data.entry_index;
	assign start_pos    = out_data.start_pos;
	assign end_pos      = out_data.end_pos;
	assign text_len     = out_data.text_len;
	assign code_unit    = out_data.code_unit;
	assign parse_status = out_data.parse_status;
	assign entry_count  = out_data.entry_count;

endmodule

// File: rtl/core/ams_checker.sv
// ----------------------------------------------------------------------------
// ams_checker
// Port-level checks of the annotation metadata stream parser.
// ----------------------------------------------------------------------------
module ams_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  item_kind,
	input logic [11:0] entry_index,
	input logic [15:0] code_unit,
	input logic [1:0]  parse_status,
	input logic [11:0] entry_count
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(item_kind)
			&& $stable(code_unit))
		else $error("stalled result changed");

	a_stall_needs_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with no pending result");

	a_unit_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && item_kind == ams_pkg::KIND_UNIT |-> code_unit != 16'd0)
		else $error("zero code unit transferred");

	a_status_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && item_kind == ams_pkg::KIND_STATUS
			&& parse_status != ams_pkg::ST_OK |-> entry_count == 12'd0
			&& entry_index == 12'd0)
		else $error("failed status carries an entry count");

	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> item_kind == ams_pkg::KIND_HEADER
			|| item_kind == ams_pkg::KIND_UNIT || item_kind == ams_pkg::KIND_STATUS)
		else $error("result kind out of range");

endmodule

bind annotation_metadata_stream_parser ams_checker u_ams_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.item_kind    (item_kind),
	.entry_index  (entry_index),
	.code_unit    (code_unit),
	.parse_status (parse_status),
	.entry_count  (entry_count)
);

// File: tb/sv/annotation_metadata_stream_parser_tb.sv
// ----------------------------------------------------------------------------
// annotation_metadata_stream_parser_tb
// Streams documents into the parser one byte per transfer and checks every
// header, code unit and final status against an in-bench parse model. Runs a
// directed set of documents, then random well-formed, corrupted and truncated
// documents under several limit settings, with random gaps on both channels
// and a long output hold-off that backs up the input side.
// ----------------------------------------------------------------------------
module annotation_metadata_stream_parser_tb;

	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_CLOSE = 8'h7D;
	localparam int QUIET_LIMIT = 4000;

	typedef enum logic [3:0] {
		PH_SEARCH, PH_COUNT, PH_START, PH_END, PH_LEN, PH_HEX, PH_SEMI, PH_CLOSE, PH_AFTER
	} phase_t;

	typedef struct packed {
		logic [7:0] value;
		logic       is_last;
	} doc_byte_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte = 8'd0;
	logic        last_byte = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  item_kind;
	logic [11:0] entry_index;
	logic [30:0] start_pos;
	logic [30:0] end_pos;
	logic [15:0] text_len;
	logic [15:0] code_unit;
	logic [1:0]  parse_status;
	logic [11:0] entry_count;
	logic        cfg_write = 1'b0;
	logic [1:0]  cfg_index = 2'd0;
	logic [30:0] cfg_data = 31'd0;

	annotation_metadata_stream_parser dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.data_byte(data_byte), .last_byte(last_byte),
		.out_valid(out_valid), .out_stall(out_stall),
		.item_kind(item_kind), .entry_index(entry_index),
		.start_pos(start_pos), .end_pos(end_pos), .text_len(text_len),
		.code_unit(code_unit), .parse_status(parse_status), .entry_count(entry_count),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// limit shadows
	logic [11:0] lim_count = ams_pkg::COUNT_LIMIT_RST;
	logic [15:0] lim_text  = ams_pkg::TEXT_LIMIT_RST;
	logic [30:0] lim_pos   = ams_pkg::POSITION_LIMIT_RST;
	logic [25:0] lim_group = ams_pkg::GROUP_LIMIT_RST;

	// parse model state
	int          mark_pos;
	phase_t      phase;
	logic [31:0] num;
	logic        dig;
	logic [11:0] decl;
	logic [11:0] done;
	logic [30:0] hstart;
	logic [30:0] hend;
	logic [15:0] units;
	logic [1:0]  hexpos;
	logic [15:0] hexacc;
	logic [25:0] gbytes;
	logic        err;

	ams_pkg::ams_result_t parsed_records[$];
	doc_byte_t            byte_q[$];
	logic [7:0]           doc[$];

	int idle_pct = 25;
	int gap_left = 0;
	int stall_left = 0;
	int hold_left = 0;
	int results_seen = 0;
	int mismatches = 0;
	int quiet = 0;

	function automatic void clear_parse();
		mark_pos = 0; phase = PH_SEARCH; num = 0; dig = 1'b0; decl = 0; done = 0;
		hstart = 0; hend = 0; units = 0; hexpos = 0; hexacc = 0; gbytes = 0;
		err = 1'b0;
	endfunction

	initial clear_parse();

	function automatic bit marker_step(input logic [7:0] b);
		if (mark_pos >= ams_pkg::MARK_LEN) mark_pos = 0;
		if (b == ams_pkg::MARKER[mark_pos]) begin
			mark_pos++;
			if (mark_pos == ams_pkg::MARK_LEN) begin
				mark_pos = 0;
				return 1'b1;
			end
		end else begin
			mark_pos = (b == ams_pkg::MARKER[0]) ? 1 : 0;
		end
		return 1'b0;
	endfunction

	function automatic int hex_value(input logic [7:0] b);
		if (b >= 8'h30 && b <= 8'h39) return b - 8'h30;
		if (b >= 8'h41 && b <= 8'h46) return b - 8'h41 + 10;
		if (b >= 8'h61 && b <= 8'h66) return b - 8'h61 + 10;
		return -1;
	endfunction

	// 0 digit taken, 1 delimiter taken, -1 malformed
	function automatic int num_step(input logic [7:0] b, input logic [7:0] delim,
			input logic [31:0] limit);
		logic [63:0] nxt;
		if (b >= CH_0 && b <= CH_9) begin
			nxt = {32'd0, num} * 64'd10 + {56'd0, b} - 64'd48;
			if (nxt > {32'd0, limit}) return -1;
			num = nxt[31:0];
			dig = 1'b1;
			return 0;
		end
		if (b == delim && dig) return 1;
		return -1;
	endfunction

	task automatic step_parser(input logic [7:0] b, input logic is_last);
		ams_pkg::ams_result_t r;
		int                   emit;
		int                   h;
		logic [15:0]          unit;
		logic [31:0]          lim;
		logic [31:0]          gnext;
		r = '0;
		emit = 0;
		unit = 0;
		if (!err && phase != PH_SEARCH && phase != PH_AFTER) begin
			gnext = {6'd0, gbytes} + 32'd1;
			if (gnext > {6'd0, lim_group}) err = 1'b1;
			else gbytes = gnext[25:0];
		end
		if (!err) begin
			case (phase)
				PH_SEARCH: begin
					if (marker_step(b)) begin
						phase = PH_COUNT; num = 0; dig = 1'b0;
						gbytes = 26'(ams_pkg::MARK_LEN);
						if (ams_pkg::MARK_LEN > lim_group) err = 1'b1;
					end
				end
				PH_COUNT: begin
					h = num_step(b, CH_SEMI, {20'd0, lim_count});
					if (h < 0) err = 1'b1;
					else if (h == 1) begin
						decl = num[11:0];
						done = 0;
						phase = (decl == 0) ? PH_CLOSE : PH_START;
						num = 0; dig = 1'b0;
					end
				end
				PH_START, PH_END, PH_LEN: begin
					lim = (phase == PH_LEN) ? {16'd0, lim_text} : {1'b0, lim_pos};
					h = num_step(b, CH_COMMA, lim);
					if (h < 0) err = 1'b1;
					else if (h == 1) begin
						if (phase == PH_START) begin
							hstart = num[30:0];
							phase = PH_END;
						end else if (phase == PH_END) begin
							hend = num[30:0];
							if (hend < hstart) err = 1'b1;
							else phase = PH_LEN;
						end else if (num == 0) begin
							err = 1'b1;
						end else begin
							units = num[15:0];
							hexpos = 0; hexacc = 0;
							phase = PH_HEX;
							emit = 1;
						end
						num = 0; dig = 1'b0;
					end
				end
				PH_HEX: begin
					h = hex_value(b);
					if (h < 0) err = 1'b1;
					else begin
						hexacc = {hexacc[11:0], h[3:0]};
						if (hexpos == 2'd3) begin
							hexpos = 0;
							if (hexacc == 0) err = 1'b1;
							else begin
								unit = hexacc;
								hexacc = 0;
								emit = 2;
								if (units > 0) units--;
								if (units == 0) phase = PH_SEMI;
							end
						end else begin
							hexpos++;
						end
					end
				end
				PH_SEMI: begin
					if (b != CH_SEMI) err = 1'b1;
					else begin
						done = done + 12'd1;
						phase = (done >= decl) ? PH_CLOSE : PH_START;
					end
				end
				PH_CLOSE: begin
					if (b != CH_CLOSE) err = 1'b1;
					else begin
						phase = PH_AFTER;
						mark_pos = 0;
					end
				end
				PH_AFTER: begin
					if (marker_step(b)) err = 1'b1;
				end
				default: err = 1'b1;
			endcase
		end
		if (is_last) begin
			r.item_kind = ams_pkg::KIND_STATUS;
			if (err) r.parse_status = ams_pkg::ST_MALFORMED;
			else if (phase == PH_SEARCH) r.parse_status = ams_pkg::ST_NOT_FOUND;
			else if (phase == PH_AFTER) begin
				r.parse_status = ams_pkg::ST_OK;
				r.entry_count = decl;
			end else r.parse_status = ams_pkg::ST_MALFORMED;
			parsed_records.push_back(r);
			clear_parse();
		end else if (!err && emit == 1) begin
			r.item_kind = ams_pkg::KIND_HEADER;
			r.entry_index = done;
			r.start_pos = hstart;
			r.end_pos = hend;
			r.text_len = units;
			parsed_records.push_back(r);
		end else if (!err && emit == 2) begin
			r.item_kind = ams_pkg::KIND_UNIT;
			r.entry_index = done;
			r.code_unit = unit;
			parsed_records.push_back(r);
		end
	endtask

	function automatic int gap_len();
		if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	function automatic string fmt_rec(input ams_pkg::ams_result_t r);
		return $sformatf("kind=%0d idx=%0d start=%0d end=%0d len=%0d unit=%h st=%0d cnt=%0d",
			r.item_kind, r.entry_index, r.start_pos, r.end_pos, r.text_len, r.code_unit,
			r.parse_status, r.entry_count);
	endfunction

	// input driver
	always @(posedge clk) begin : driver
		logic      offering;
		doc_byte_t cur;
		offering = in_valid;
		if (in_valid && !in_stall) begin
			step_parser(data_byte, last_byte);
			offering = 1'b0;
		end
		if (!offering) begin
			if (gap_left > 0) begin
				gap_left--;
			end else if (byte_q.size() != 0) begin
				cur = byte_q.pop_front();
				data_byte <= cur.value;
				last_byte <= cur.is_last;
				offering = 1'b1;
				gap_left = ($urandom_range(0, 99) < idle_pct) ? gap_len() : 0;
			end
		end
		in_valid <= offering;
	end

	// output monitor and stall generator
	always @(posedge clk) begin : monitor
		ams_pkg::ams_result_t got;
		ams_pkg::ams_result_t want;
		logic                 bad;
		logic                 stall_nxt;
		if (out_valid && !out_stall) begin
			got = {item_kind, entry_index, start_pos, end_pos, text_len, code_unit,
				parse_status, entry_count};
			if (parsed_records.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected transfer: %s", fmt_rec(got));
			end else begin
				want = parsed_records.pop_front();
				bad = got.item_kind !== want.item_kind || got.entry_index !== want.entry_index
					|| got.start_pos !== want.start_pos || got.end_pos !== want.end_pos
					|| got.text_len !== want.text_len || got.code_unit !== want.code_unit
					|| got.parse_status !== want.parse_status
					|| got.entry_count !== want.entry_count;
				if (bad) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch at result %0d", results_seen);
						$display("  expected %s", fmt_rec(want));
						$display("  actual   %s", fmt_rec(got));
					end
				end
			end
			results_seen++;
			if (results_seen == 25 || results_seen == 90) hold_left = 300;
		end
		if (hold_left > 0) begin
			hold_left--;
			stall_nxt = 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			stall_nxt = 1'b1;
		end else begin
			stall_nxt = 1'b0;
			if ($urandom_range(0, 99) < idle_pct) stall_left = gap_len();
		end
		out_stall <= stall_nxt;
	end

	// watchdog
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
		else quiet++;
		if (quiet >= QUIET_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++) doc.push_back(s[i]);
	endtask

	task automatic push_marker();
		for (int i = 0; i < ams_pkg::MARK_LEN; i++) doc.push_back(ams_pkg::MARKER[i]);
	endtask

	task automatic push_dec(input longint unsigned v);
		if ($urandom_range(0, 15) == 0) doc.push_back(CH_0);
		push_text($sformatf("%0d", v));
	endtask

	task automatic push_unit(input logic [15:0] u);
		string      s;
		logic [7:0] c;
		s = $sformatf("%04x", u);
		for (int i = 0; i < 4; i++) begin
			c = s[i];
			if (c >= 8'h61 && $urandom_range(0, 1)) c = c - 8'h20;
			doc.push_back(c);
		end
	endtask

	task automatic finish_doc(output int n);
		n = doc.size();
		for (int i = 0; i < n; i++) byte_q.push_back('{value: doc[i], is_last: (i == n - 1)});
		doc.delete();
	endtask

	function automatic longint unsigned pick_pos();
		int r;
		r = $urandom_range(0, 9);
		if (r < 7) return $urandom_range(0, (lim_pos < 999) ? lim_pos : 999);
		if (r < 9) return $urandom % ({1'b0, lim_pos} + 32'd1);
		return longint'(lim_pos) + 1;
	endfunction

	task automatic build_random_doc();
		int              n;
		int              len;
		int              cut;
		int              hi;
		longint unsigned s;
		longint unsigned e;
		repeat ($urandom_range(0, 4)) doc.push_back(8'($urandom_range(0, 255)));
		if ($urandom_range(0, 99) < 6) begin
			cut = $urandom_range(1, ams_pkg::MARK_LEN - 1);
			for (int k = 0; k < cut; k++) doc.push_back(ams_pkg::MARKER[k]);
		end else begin
			push_marker();
			hi = (lim_count < 3) ? lim_count : 3;
			n = $urandom_range(0, hi);
			if ($urandom_range(0, 19) == 0) push_dec(lim_count + 1 + $urandom_range(0, 5));
			else push_dec(n);
			doc.push_back(CH_SEMI);
			for (int k = 0; k < n; k++) begin
				s = pick_pos();
				e = s + $urandom_range(0, 50);
				if (e > lim_pos && s <= lim_pos) e = lim_pos;
				if ($urandom_range(0, 19) == 0 && s > 0) e = s - 1;
				push_dec(s);
				doc.push_back(CH_COMMA);
				push_dec(e);
				doc.push_back(CH_COMMA);
				hi = (lim_text < 3) ? lim_text : 3;
				len = $urandom_range(1, hi);
				if ($urandom_range(0, 29) == 0) push_dec(0);
				else if ($urandom_range(0, 29) == 0) push_dec(lim_text + 1);
				else push_dec(len);
				doc.push_back(CH_COMMA);
				repeat (len)
					push_unit(($urandom_range(0, 39) == 0) ? 16'd0
						: 16'($urandom_range(1, 65535)));
				doc.push_back(CH_SEMI);
			end
			doc.push_back(CH_CLOSE);
			repeat ($urandom_range(0, 3)) doc.push_back(8'($urandom_range(0, 255)));
		end
		case ($urandom_range(0, 11))
			0: doc[$urandom_range(0, doc.size() - 1)] = 8'($urandom_range(0, 255));
			1, 2: begin
				if (doc.size() > 1) begin
					cut = $urandom_range(1, doc.size() - 1);
					while (doc.size() > cut) void'(doc.pop_back());
				end
			end
			3: push_marker();
			default: ;
		endcase
	endtask

	task automatic random_docs(input int target);
		int sent;
		int n;
		sent = 0;
		while (sent < target) begin
			build_random_doc();
			finish_doc(n);
			sent += n;
		end
	endtask

	task automatic marker_doc(input string tail);
		int n;
		push_marker();
		push_text(tail);
		finish_doc(n);
	endtask

	task automatic text_doc(input string s);
		int n;
		push_text(s);
		finish_doc(n);
	endtask

	task automatic settle();
		while (byte_q.size() != 0 || in_valid || parsed_records.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_limit(input logic [1:0] idx, input logic [30:0] v);
		logic [30:0] mask;
		logic [30:0] data;
		case (idx)
			ams_pkg::REG_COUNT_LIMIT:    mask = 31'h0000_0FFF;
			ams_pkg::REG_TEXT_LIMIT:     mask = 31'h0000_FFFF;
			ams_pkg::REG_POSITION_LIMIT: mask = 31'h7FFF_FFFF;
			default:                     mask = 31'h03FF_FFFF;
		endcase
		data = (31'($urandom) & ~mask) | (v & mask);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			ams_pkg::REG_COUNT_LIMIT:    lim_count = data[11:0];
			ams_pkg::REG_TEXT_LIMIT:     lim_text = data[15:0];
			ams_pkg::REG_POSITION_LIMIT: lim_pos = data;
			default:                     lim_group = data[25:0];
		endcase
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	initial begin
		int n;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed documents under reset limits
		marker_doc("2;0,5,2,0041004a;7,7,1,FfFf;}");
		marker_doc("0;}xy");
		text_doc("hello");
		for (int k = 0; k < 10; k++) doc.push_back(ams_pkg::MARKER[k]);
		finish_doc(n);
		marker_doc("1025;");
		marker_doc(";");
		marker_doc("1;a");
		marker_doc("1;5,4,1,0041;}");
		marker_doc("1;0,0,0,;}");
		marker_doc("1;0,0,1,0000;}");
		push_marker();
		push_text("0;}");
		marker_doc("");
		marker_doc("1;0,1,1,00");
		marker_doc("1;0,1,1,0041");
		push_marker();
		push_text("1;x");
		marker_doc("0;}");
		text_doc("{");
		push_text("{");
		marker_doc("0;}");
		marker_doc("1;2147483647,2147483647,1,abcd;}");
		marker_doc("1;2147483648,");
		marker_doc("1;1,2,2,0001;");
		marker_doc("1;1,1,1,0001,}");
		random_docs(30);
		settle();

		write_limit(ams_pkg::REG_COUNT_LIMIT, 31'd4095);
		write_limit(ams_pkg::REG_TEXT_LIMIT, 31'd65535);
		write_limit(ams_pkg::REG_POSITION_LIMIT, 31'h7FFF_FFFF);
		write_limit(ams_pkg::REG_GROUP_LIMIT, 31'h03FF_FFFF);
		idle_pct = 0;
		marker_doc("4095;}");
		random_docs(15);
		settle();

		write_limit(ams_pkg::REG_COUNT_LIMIT, 31'd0);
		write_limit(ams_pkg::REG_TEXT_LIMIT, 31'd1);
		write_limit(ams_pkg::REG_POSITION_LIMIT, 31'd0);
		write_limit(ams_pkg::REG_GROUP_LIMIT, 31'd40);
		idle_pct = 40;
		marker_doc("0;}");
		marker_doc("1;");
		random_docs(15);
		settle();

		// group limit right at and just below a minimal group
		write_limit(ams_pkg::REG_GROUP_LIMIT, 31'd28);
		marker_doc("0;}");
		settle();
		write_limit(ams_pkg::REG_GROUP_LIMIT, 31'd27);
		marker_doc("0;}");
		settle();
		write_limit(ams_pkg::REG_GROUP_LIMIT, 31'd1);
		marker_doc("0;}");
		text_doc("abc");
		settle();

		write_limit(ams_pkg::REG_COUNT_LIMIT, 31'd3);
		write_limit(ams_pkg::REG_TEXT_LIMIT, 31'd2);
		write_limit(ams_pkg::REG_POSITION_LIMIT, 31'd1000);
		write_limit(ams_pkg::REG_GROUP_LIMIT, 31'd90);
		idle_pct = 20;
		random_docs(15);
		settle();

		write_limit(ams_pkg::REG_COUNT_LIMIT, 31'(ams_pkg::COUNT_LIMIT_RST));
		write_limit(ams_pkg::REG_TEXT_LIMIT, 31'(ams_pkg::TEXT_LIMIT_RST));
		write_limit(ams_pkg::REG_POSITION_LIMIT, ams_pkg::POSITION_LIMIT_RST);
		write_limit(ams_pkg::REG_GROUP_LIMIT, 31'(ams_pkg::GROUP_LIMIT_RST));
		idle_pct = 25;
		random_docs(15);

		settle();
		repeat (4) @(posedge clk);
		if (mismatches == 0 && parsed_records.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// File: annotation_metadata_stream_parser.f
rtl/core/ams_pkg.sv
rtl/core/ams_parser.sv
rtl/core/ams_out_buf.sv
rtl/core/annotation_metadata_stream_parser.sv
rtl/core/ams_checker.sv
tb/sv/annotation_metadata_stream_parser_tb.sv
